@@ rtl/ksva_pkg.sv @@
// shared types and constants of the keyboard scan voice allocator
`default_nettype none

package ksva_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_ALLOC,
    ST_CLEAR,
    ST_WRITE
  } state_e;

  // action codes
  localparam logic [2:0] ACT_SCAN      = 3'd0;
  localparam logic [2:0] ACT_ALLOC     = 3'd1;
  localparam logic [2:0] ACT_NOTE_ON   = 3'd2;
  localparam logic [2:0] ACT_NOTE_OFF  = 3'd3;
  localparam logic [2:0] ACT_ALL_OFF   = 3'd4;
  localparam logic [2:0] ACT_CLR_FLAGS = 3'd5;

  // field widths
  localparam int KeyVecW = 43;
  localparam int NoteW   = 7;
  localparam int CountW  = 6;
  localparam int AuxW    = 3;
  localparam int KeyIdxW = 6;

  // keyboard layout
  localparam int KeyBaseNote = 36;
  localparam int KbLimit     = 41;
  localparam int ModeBit     = 41;
  localparam int AuxBit      = 42;
  localparam int AuxWrap     = 7;
  localparam int HeldMax     = 63;
  localparam int OutSlots    = 4;

  // sticky flag positions
  localparam int FlagMode = 0;
  localparam int FlagAuxP = 1;
  localparam int FlagAuxR = 2;
  localparam int FlagW    = 3;

endpackage

`default_nettype wire

@@ rtl/keyboard_scan_voice_allocator.sv @@
// top level: keyboard scanner and first-free polyphonic voice allocator
`default_nettype none

// Keyboard scanner and first-free voice allocator. The block holds a note
// on/off map of NUM_NOTES notes and NUM_VOICES voice slots (slot value 0
// means free). Every accepted input transfer produces exactly one output
// transfer that shows the full state after the action. One item is worked at
// a time and in_ready_o stays low until its result is in the output register.
// The note map is a one-bit memory with one write and one registered read per
// cycle. After reset it is cleared one entry per cycle, and in_ready_o stays
// low until that clearing pass is done. A key scan walks the keyboard keys
// one per cycle through the shared edge/count unit: the accept, a walk of
// min(NUM_KEYS,41) keys, a closing step for the mode and aux keys and the load
// of the result. An allocate pass walks the notes one per cycle through the
// shared slot comparator bank: the accept, a walk of NUM_NOTES notes and the
// load. All notes off walks the map the same way to clear it. Note on, note
// off, clear flags and the unused codes go from the accept straight to the
// load. The output register lets the next item start while a result still
// waits for out_ready_i; the length of the key or note walk, plus any output
// stall at load time, sets how long an item takes.
module keyboard_scan_voice_allocator import ksva_pkg::*; #(
  parameter int NUM_VOICES = 4,
  parameter int NUM_NOTES  = 128,
  parameter int NUM_KEYS   = 41
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [KeyVecW-1:0] key_vector_i,
  input  wire logic [NoteW-1:0]   note_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [NoteW-1:0]        voice_a_o,
  output logic [NoteW-1:0]        voice_b_o,
  output logic [NoteW-1:0]        voice_c_o,
  output logic [NoteW-1:0]        voice_d_o,
  output logic [CountW-1:0]       keys_down_o,
  output logic [CountW-1:0]       held_keys_o,
  output logic                    mode_pressed_o,
  output logic                    aux_pressed_o,
  output logic                    aux_released_o,
  output logic [AuxW-1:0]         aux_step_o
);

  // keyboard keys actually scanned, capped below the mode key
  localparam int NumKeysUsed = (NUM_KEYS < KbLimit) ? NUM_KEYS : KbLimit;
  localparam int MapIdxW     = $clog2(NUM_NOTES);

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   load_out;
  logic   scan_step;
  logic   scan_end;
  logic   alloc_step;
  logic   clr_step;

  // block state
  logic                 note_mem [NUM_NOTES];
  logic [KeyVecW-1:0]   prev_keys_q;
  logic [KeyVecW-1:0]   scan_vec_q;
  logic [NoteW-1:0]     slot_q [NUM_VOICES];
  logic [NoteW-1:0]     slot_d [NUM_VOICES];
  logic [CountW-1:0]    keys_down_q;
  logic [CountW-1:0]    held_q;
  logic [AuxW-1:0]      aux_idx_q;
  logic [FlagW-1:0]     flags_q;

  // walk counters
  logic [KeyIdxW-1:0]   key_idx_q;
  logic [MapIdxW-1:0]   note_cnt_q;

  // output register
  logic                 out_valid_q;
  logic [NoteW-1:0]     out_voice_q [OutSlots];
  logic [NoteW-1:0]     slot_view   [OutSlots];
  logic [CountW-1:0]    out_keys_down_q;
  logic [CountW-1:0]    out_held_q;
  logic [FlagW-1:0]     out_flags_q;
  logic [AuxW-1:0]      out_aux_q;

  // key edge unit
  logic                 key_now;
  logic                 key_was;
  logic [7:0]           key_note;
  logic                 key_in_map;
  logic                 last_key;

  // mode and aux key edges, evaluated in the closing cycle of a scan
  logic                 mode_rise;
  logic                 aux_rise;
  logic                 aux_fall;
  logic [AuxW-1:0]      aux_next;

  // note map write port
  logic                 map_we;
  logic [MapIdxW-1:0]   map_addr;
  logic                 map_data;

  // note map read port, data registered and valid in the cycle after the address
  logic                 rd_en;
  logic [MapIdxW-1:0]   rd_addr;
  logic                 note_rd_q;

  // slot comparator bank
  logic [NoteW-1:0]     cur_note;
  logic                 cur_on;
  logic [NUM_VOICES-1:0] slot_match;
  logic [NUM_VOICES-1:0] slot_free;
  logic [NUM_VOICES-1:0] slot_grant;
  logic                 last_note;

  assign accept = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_SCAN) begin
            state_d = ST_SCAN;
          end else if (action_i == ACT_ALLOC) begin
            state_d = ST_ALLOC;
          end else if (action_i == ACT_ALL_OFF) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      // clearing pass after reset, no result
      ST_INIT: begin
        if (last_note) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (last_key) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_WRITE;
      end
      ST_ALLOC: begin
        if (last_note) begin
          state_d = ST_WRITE;
        end
      end
      ST_CLEAR: begin
        if (last_note) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    scan_step  = 1'b0;
    scan_end   = 1'b0;
    alloc_step = 1'b0;
    clr_step   = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_INIT:     clr_step   = 1'b1;
      ST_SCAN:     scan_step  = 1'b1;
      ST_SCAN_END: scan_end   = 1'b1;
      ST_ALLOC:    alloc_step = 1'b1;
      ST_CLEAR:    clr_step   = 1'b1;
      ST_WRITE:    load_out   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // key edge unit: one keyboard key per cycle
  // ---------------------------------------------------------------------------
  assign key_now    = scan_vec_q[key_idx_q];
  assign key_was    = prev_keys_q[key_idx_q];
  assign key_note   = 8'(KeyBaseNote) + {2'b00, key_idx_q};
  // keyboard notes past the top of the map are dropped
  assign key_in_map = {1'b0, key_note} < 9'(NUM_NOTES);
  assign last_key   = key_idx_q == KeyIdxW'(NumKeysUsed - 1);

  assign mode_rise = scan_vec_q[ModeBit] && !prev_keys_q[ModeBit];
  assign aux_rise  = scan_vec_q[AuxBit] && !prev_keys_q[AuxBit];
  assign aux_fall  = !scan_vec_q[AuxBit] && prev_keys_q[AuxBit];
  // aux index wraps after six
  assign aux_next  = (aux_idx_q == AuxW'(AuxWrap - 1)) ? '0 : aux_idx_q + 1'b1;

  // ---------------------------------------------------------------------------
  // note map write port: external note on/off, a keyboard edge or a clear walk
  // ---------------------------------------------------------------------------
  always_comb begin
    map_we    = 1'b0;
    map_addr  = '0;
    map_data  = 1'b0;
    if (accept) begin
      unique case (action_i) inside
        ACT_NOTE_ON, ACT_NOTE_OFF: begin
          map_we   = {1'b0, note_i} < 8'(NUM_NOTES);
          map_addr = note_i[MapIdxW-1:0];
          map_data = action_i == ACT_NOTE_ON;
        end
        default: begin
          map_we = 1'b0;
        end
      endcase
    end else if (scan_step) begin
      map_we   = (key_now ^ key_was) && key_in_map;
      map_addr = key_note[MapIdxW-1:0];
      map_data = key_now;
    end else if (clr_step) begin
      map_we   = 1'b1;
      map_addr = note_cnt_q;
      map_data = 1'b0;
    end
  end

  // note map read port: note 0 is fetched at the accept of an allocate pass,
  // then each walk cycle fetches the following note
  assign rd_en   = (accept && action_i == ACT_ALLOC) || (alloc_step && !last_note);
  assign rd_addr = accept ? '0 : note_cnt_q + 1'b1;

  // ---------------------------------------------------------------------------
  // slot comparator bank: one note per cycle against every voice slot
  // ---------------------------------------------------------------------------
  assign cur_note  = NoteW'(note_cnt_q);
  assign cur_on    = note_rd_q;
  assign last_note = note_cnt_q == MapIdxW'(NUM_NOTES - 1);

  always_comb begin
    logic found;
    found = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      slot_match[v] = slot_q[v] == cur_note;
      slot_free[v]  = slot_q[v] == '0;
      // lowest free slot wins
      slot_grant[v] = slot_free[v] && !found;
      found         = found || slot_free[v];
    end
  end

  // note 0 never gets a voice: while slots are free it counts as playing
  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      slot_d[v] = slot_q[v];
      if (!cur_on && slot_match[v]) begin
        slot_d[v] = '0;
      end else if (cur_on && !(|slot_match) && slot_grant[v]) begin
        slot_d[v] = cur_note;
      end
    end
  end

  // slots beyond the configured voice count read as free
  for (genvar g = 0; g < OutSlots; g++) begin : g_view
    if (g < NUM_VOICES) begin : g_used
      assign slot_view[g] = slot_q[g];
    end else begin : g_unused
      assign slot_view[g] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      prev_keys_q <= '0;
      keys_down_q <= '0;
      held_q      <= '0;
      aux_idx_q   <= '0;
      flags_q     <= '0;
      key_idx_q   <= '0;
      note_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        slot_q[v] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (accept) begin
        key_idx_q  <= '0;
        note_cnt_q <= '0;
        if (action_i == ACT_SCAN) begin
          keys_down_q <= '0;
        end
        if (action_i == ACT_CLR_FLAGS) begin
          flags_q <= '0;
        end
      end

      if (scan_step) begin
        key_idx_q <= key_idx_q + 1'b1;
        if (key_now) begin
          keys_down_q <= keys_down_q + 1'b1;
        end
        // held count saturates at the top and floors at zero
        if (key_now && !key_was && held_q != CountW'(HeldMax)) begin
          held_q <= held_q + 1'b1;
        end else if (!key_now && key_was && held_q != '0) begin
          held_q <= held_q - 1'b1;
        end
      end

      if (scan_end) begin
        if (mode_rise) begin
          flags_q[FlagMode] <= 1'b1;
        end
        if (aux_rise) begin
          flags_q[FlagAuxP] <= 1'b1;
          aux_idx_q         <= aux_next;
        end
        if (aux_fall) begin
          flags_q[FlagAuxR] <= 1'b1;
        end
        prev_keys_q <= scan_vec_q;
      end

      if (alloc_step || clr_step) begin
        note_cnt_q <= note_cnt_q + 1'b1;
      end

      if (alloc_step) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          slot_q[v] <= slot_d[v];
        end
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // note map memory
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      note_mem[map_addr] <= map_data;
    end
    if (rd_en) begin
      note_rd_q <= note_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && action_i == ACT_SCAN) begin
      scan_vec_q <= key_vector_i;
    end
    if (load_out) begin
      for (int v = 0; v < OutSlots; v++) begin
        out_voice_q[v] <= slot_view[v];
      end
      out_keys_down_q <= keys_down_q;
      out_held_q      <= held_q;
      out_flags_q     <= flags_q;
      out_aux_q       <= aux_idx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output ports
  // ---------------------------------------------------------------------------
  assign out_valid_o    = out_valid_q;
  assign voice_a_o      = out_voice_q[0];
  assign voice_b_o      = out_voice_q[1];
  assign voice_c_o      = out_voice_q[2];
  assign voice_d_o      = out_voice_q[3];
  assign keys_down_o    = out_keys_down_q;
  assign held_keys_o    = out_held_q;
  assign mode_pressed_o = out_flags_q[FlagMode];
  assign aux_pressed_o  = out_flags_q[FlagAuxP];
  assign aux_released_o = out_flags_q[FlagAuxR];
  assign aux_step_o     = out_aux_q;

endmodule

`default_nettype wire

@@ rtl/ksva_checker.sv @@
// port level checker of the voice allocator and its bind
`default_nettype none

module ksva_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [6:0] voice_a_i,
  input wire logic [6:0] voice_b_i,
  input wire logic [6:0] voice_c_i,
  input wire logic [6:0] voice_d_i,
  input wire logic [5:0] keys_down_i,
  input wire logic [2:0] aux_step_i
);

  // a stalled result holds its voices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(voice_a_i)
      && $stable(voice_b_i) && $stable(voice_c_i) && $stable(voice_d_i))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready again right after a transfer");

  // a note never sits in two voices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      !((voice_a_i != '0) && (voice_a_i == voice_b_i || voice_a_i == voice_c_i
                              || voice_a_i == voice_d_i))
      && !((voice_b_i != '0) && (voice_b_i == voice_c_i || voice_b_i == voice_d_i))
      && !((voice_c_i != '0) && (voice_c_i == voice_d_i)))
    else $error("note allocated to two voices");

  // counters stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> aux_step_i <= 3'd6 && keys_down_i <= 6'd41)
    else $error("aux step or key count out of range");

endmodule

bind keyboard_scan_voice_allocator ksva_checker u_ksva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .voice_a_i   (voice_a_o),
  .voice_b_i   (voice_b_o),
  .voice_c_i   (voice_c_o),
  .voice_d_i   (voice_d_o),
  .keys_down_i (keys_down_o),
  .aux_step_i  (aux_step_o)
);

`default_nettype wire
